/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/eesb_pkg.sv */
// ----------------------------------------------------------------------------
// eesb_pkg
// shared types and codes of the expiring entry select buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eesb_pkg;

	localparam int BUFFER_DEPTH_DEF = 16;

	localparam int CMD_W    = 2;
	localparam int TIME_W   = 32;
	localparam int TAG_W    = 8;
	localparam int KIND_W   = 3;
	localparam int PRIO_W   = 8;
	localparam int POL_W    = 3;
	localparam int OIDX_W   = 4;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

	localparam logic [POL_W-1:0] POL_FIRST_LIVE = 3'd0;
	localparam logic [POL_W-1:0] POL_LAST_LIVE  = 3'd1;
	localparam logic [POL_W-1:0] POL_FIRST      = 3'd2;
	localparam logic [POL_W-1:0] POL_LAST       = 3'd3;
	localparam logic [POL_W-1:0] POL_HIGH_PRIO  = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 1'd1;

	typedef struct packed {
		logic [POL_W-1:0] policy;
		logic             enable;
	} cfg_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [KIND_W-1:0] kind;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] push_time;
		logic [TIME_W-1:0] lifetime;
	} entry_t;

endpackage

/* hdl/eesb_ram.sv */
// ----------------------------------------------------------------------------
// eesb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eesb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/eesb_cfg.sv */
// ----------------------------------------------------------------------------
// eesb_cfg
// apb register file holding the select policy and the capture enable
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eesb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [eesb_pkg::APB_AW-1:0]   paddr,
	input  logic [eesb_pkg::APB_DW-1:0]   pwdata,
	output logic [eesb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output eesb_pkg::cfg_t                cfg
);

	logic [eesb_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr;
	logic [eesb_pkg::POL_W-1:0]     policy_q;
	logic                           enable_q;

	assign reg_idx = paddr[eesb_pkg::APB_AW-1:2];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= eesb_pkg::POL_HIGH_PRIO;
			enable_q <= 1'b1;
		end else if (wr) begin
			case (reg_idx)
				eesb_pkg::REG_POLICY: begin
					policy_q <= pwdata[eesb_pkg::POL_W-1:0];
				end
				eesb_pkg::REG_ENABLE: begin
					enable_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			eesb_pkg::REG_POLICY: prdata = eesb_pkg::APB_DW'(policy_q);
			eesb_pkg::REG_ENABLE: prdata = eesb_pkg::APB_DW'(enable_q);
			default:              prdata = '0;
		endcase
	end

	assign cfg.policy = policy_q;
	assign cfg.enable = enable_q;

endmodule

/* hdl/expiring_entry_select_buffer.sv */
// ----------------------------------------------------------------------------
// expiring_entry_select_buffer
// entry buffer in ram with clear, push and policy driven select
// ----------------------------------------------------------------------------
// A clear, a push or an unused command is taken at once and its result
// word is strobed on done in the next cycle; busy stays low, so these can be
// issued back to back. A select walks the stored entries through the entry
// ram, one read a cycle, until the whole buffer is scanned or a first or
// last policy hits early; when disabled or empty its result word comes in
// the next cycle like a push. busy is high for the scan. Result words are
// shown for one cycle only and cannot be held off by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module expiring_entry_select_buffer #(
	parameter int BUFFER_DEPTH = eesb_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [eesb_pkg::APB_AW-1:0]   paddr,
	input  logic [eesb_pkg::APB_DW-1:0]   pwdata,
	output logic [eesb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [eesb_pkg::CMD_W-1:0]    command,
	input  logic [eesb_pkg::TIME_W-1:0]   now_ticks,
	input  logic [eesb_pkg::TAG_W-1:0]    entry_tag,
	input  logic [eesb_pkg::KIND_W-1:0]   entry_kind,
	input  logic [eesb_pkg::PRIO_W-1:0]   entry_priority,
	input  logic [eesb_pkg::TIME_W-1:0]   entry_lifetime,
	output logic                          done,
	output logic                          accepted,
	output logic                          overflow,
	output logic                          found,
	output logic [eesb_pkg::OIDX_W-1:0]   found_index,
	output logic [eesb_pkg::TAG_W-1:0]    found_tag,
	output logic [eesb_pkg::KIND_W-1:0]   found_kind,
	output logic [eesb_pkg::PRIO_W-1:0]   found_priority
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	eesb_pkg::cfg_t   cfg;
	eesb_pkg::entry_t wr_data;
	eesb_pkg::entry_t rd_data;

	logic                          state_q;
	logic [CNT_W-1:0]              fill_q;
	logic                          take;
	logic                          full;
	logic                          wr_en;
	logic                          rd_en;

	logic [eesb_pkg::TIME_W-1:0]   now_q;
	logic                          asc_q;
	logic                          stop_q;
	logic                          any_q;
	logic [CNT_W-1:0]              rem_q;
	logic [IDX_W-1:0]              addr_q;
	logic                          valid_s1;
	logic [IDX_W-1:0]              idx_s1;

	logic                          best_found_q;
	logic [IDX_W-1:0]              best_idx_q;
	logic [eesb_pkg::TAG_W-1:0]    best_tag_q;
	logic [eesb_pkg::KIND_W-1:0]   best_kind_q;
	logic [eesb_pkg::PRIO_W-1:0]   best_prio_q;

	logic [eesb_pkg::TIME_W-1:0]   age;
	logic                          live;
	logic                          hit;
	logic                          better;
	logic                          scan_end;
	logic                          pol_last;
	logic                          pol_any;
	logic                          pol_stop;

	logic                          emit;
	logic                          e_acc;
	logic                          e_ovf;
	logic                          e_fnd;
	logic [eesb_pkg::OIDX_W-1:0]   e_idx;
	logic [eesb_pkg::TAG_W-1:0]    e_tag;
	logic [eesb_pkg::KIND_W-1:0]   e_kind;
	logic [eesb_pkg::PRIO_W-1:0]   e_prio;

	logic                          done_q;
	logic                          acc_q;
	logic                          ovf_q;
	logic                          fnd_q;
	logic [eesb_pkg::OIDX_W-1:0]   fidx_q;
	logic [eesb_pkg::TAG_W-1:0]    ftag_q;
	logic [eesb_pkg::KIND_W-1:0]   fkind_q;
	logic [eesb_pkg::PRIO_W-1:0]   fprio_q;

	eesb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	eesb_ram #(
		.WIDTH ($bits(eesb_pkg::entry_t)),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[IDX_W-1:0]),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	assign busy  = (state_q == ST_SCAN);
	assign take  = start && !busy;
	assign full  = (fill_q == CNT_W'(BUFFER_DEPTH));
	assign wr_en = take && (command == eesb_pkg::CMD_PUSH) && cfg.enable && !full;
	assign rd_en = (state_q == ST_SCAN) && (rem_q != '0);

	assign wr_data.tag       = entry_tag;
	assign wr_data.kind      = entry_kind;
	assign wr_data.prio      = entry_priority;
	assign wr_data.push_time = now_ticks;
	assign wr_data.lifetime  = entry_lifetime;

	// policy decode, unused codes act as highest priority live
	assign pol_last = (cfg.policy == eesb_pkg::POL_LAST_LIVE) ||
		(cfg.policy == eesb_pkg::POL_LAST);
	assign pol_any  = (cfg.policy == eesb_pkg::POL_FIRST) ||
		(cfg.policy == eesb_pkg::POL_LAST);
	assign pol_stop = pol_any || (cfg.policy == eesb_pkg::POL_FIRST_LIVE) ||
		(cfg.policy == eesb_pkg::POL_LAST_LIVE);

	// liveness with wrapping age
	assign age      = now_q - rd_data.push_time;
	assign live     = (rd_data.lifetime == '0) || (age <= rd_data.lifetime);
	assign hit      = valid_s1 && (any_q || live);
	assign better   = valid_s1 && live && (rd_data.prio >= best_prio_q);
	assign scan_end = (rem_q == '0) && !valid_s1;

	always_comb begin
		emit   = 1'b0;
		e_acc  = 1'b0;
		e_ovf  = 1'b0;
		e_fnd  = 1'b0;
		e_idx  = '0;
		e_tag  = '0;
		e_kind = '0;
		e_prio = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (command)
						eesb_pkg::CMD_CLEAR: begin
							emit  = 1'b1;
							e_acc = 1'b1;
						end
						eesb_pkg::CMD_PUSH: begin
							emit  = 1'b1;
							e_acc = cfg.enable && !full;
							e_ovf = cfg.enable && full;
						end
						eesb_pkg::CMD_SELECT: begin
							emit = !cfg.enable || (fill_q == '0);
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (stop_q && hit) begin
					emit   = 1'b1;
					e_fnd  = 1'b1;
					e_idx  = eesb_pkg::OIDX_W'(idx_s1);
					e_tag  = rd_data.tag;
					e_kind = rd_data.kind;
					e_prio = rd_data.prio;
				end else if (scan_end) begin
					emit = 1'b1;
					if (best_found_q) begin
						e_fnd  = 1'b1;
						e_idx  = eesb_pkg::OIDX_W'(best_idx_q);
						e_tag  = best_tag_q;
						e_kind = best_kind_q;
						e_prio = best_prio_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= emit;
			valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (command == eesb_pkg::CMD_CLEAR) begin
							fill_q <= '0;
						end else if (wr_en) begin
							fill_q <= fill_q + CNT_W'(1);
						end else if ((command == eesb_pkg::CMD_SELECT) && cfg.enable &&
							(fill_q != '0)) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (take) begin
			now_q        <= now_ticks;
			asc_q        <= !pol_last;
			stop_q       <= pol_stop;
			any_q        <= pol_any;
			rem_q        <= fill_q;
			addr_q       <= pol_last ? IDX_W'(fill_q - CNT_W'(1)) : '0;
			best_found_q <= 1'b0;
			best_prio_q  <= '0;
		end else begin
			if (rd_en) begin
				rem_q  <= rem_q - CNT_W'(1);
				addr_q <= asc_q ? addr_q + IDX_W'(1) : addr_q - IDX_W'(1);
			end
			if ((state_q == ST_SCAN) && !stop_q && better) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_s1;
				best_tag_q   <= rd_data.tag;
				best_kind_q  <= rd_data.kind;
				best_prio_q  <= rd_data.prio;
			end
		end
		if (emit) begin
			acc_q   <= e_acc;
			ovf_q   <= e_ovf;
			fnd_q   <= e_fnd;
			fidx_q  <= e_idx;
			ftag_q  <= e_tag;
			fkind_q <= e_kind;
			fprio_q <= e_prio;
		end
	end

	assign done           = done_q;
	assign accepted       = acc_q;
	assign overflow       = ovf_q;
	assign found          = fnd_q;
	assign found_index    = fidx_q;
	assign found_tag      = ftag_q;
	assign found_kind     = fkind_q;
	assign found_priority = fprio_q;

	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= CNT_W'(BUFFER_DEPTH), "fill count above depth")
	`ASSERT_IMPLIES(a_no_write_in_scan, clk, arst_n, wr_en, state_q == ST_IDLE, "ram write during scan")
	`ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, done, !busy, "result word while scanning")
	`ASSERT_IMPLIES(a_result_exclusive, clk, arst_n, done, !(found && (accepted || overflow)), "select and push flags mixed")
	`ASSERT_NEXT(a_read_from_scan, clk, arst_n, rd_en, valid_s1, "read data not tracked")

endmodule

/* dv/tb_expiring_entry_select_buffer.sv */
// ----------------------------------------------------------------------------
// tb_expiring_entry_select_buffer
// self-checking bench for the expiring entry select buffer: a queue-fed
// driver issues clear, push, select and unused command words in random
// bursts and writes the policy and enable registers over apb between phases,
// while a monitor predicts each result word and checks every field of it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_expiring_entry_select_buffer;
	import eesb_pkg::*;

	localparam int DEPTH       = BUFFER_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [POL_W-1:0] POL_SPARE  = 3'd7;

	typedef enum logic [1:0] {OP_WORD, OP_WRITE, OP_DRAIN} op_action_t;
	typedef enum logic [1:0] {BUS_IDLE, BUS_SETUP, BUS_ACCESS} bus_phase_t;

	typedef struct {
		op_action_t             action;
		logic [CMD_W-1:0]       cmd;
		logic [TIME_W-1:0]      now;
		logic [TAG_W-1:0]       tag;
		logic [KIND_W-1:0]      kind_code;
		logic [PRIO_W-1:0]      prio;
		logic [TIME_W-1:0]      lifetime;
		logic [REG_IDX_W-1:0]   reg_idx;
		logic [APB_DW-1:0]      reg_val;
	} pending_op_t;

	typedef struct packed {
		logic                accepted;
		logic                overflow;
		logic                found;
		logic [OIDX_W-1:0]   index;
		logic [TAG_W-1:0]    tag;
		logic [KIND_W-1:0]   kind;
		logic [PRIO_W-1:0]   prio;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CMD_W-1:0]     command = '0;
	logic [TIME_W-1:0]    now_ticks = '0;
	logic [TAG_W-1:0]     entry_tag = '0;
	logic [KIND_W-1:0]    entry_kind = '0;
	logic [PRIO_W-1:0]    entry_priority = '0;
	logic [TIME_W-1:0]    entry_lifetime = '0;
	logic                 done;
	logic                 accepted;
	logic                 overflow;
	logic                 found;
	logic [OIDX_W-1:0]    found_index;
	logic [TAG_W-1:0]     found_tag;
	logic [KIND_W-1:0]    found_kind;
	logic [PRIO_W-1:0]    found_priority;

	pending_op_t          pending_ops[$];
	outcome_t             predicted_results[$];

	entry_t               held_entries[DEPTH];
	int                   held_count = 0;
	logic [POL_W-1:0]     cur_policy = POL_HIGH_PRIO;
	logic                 cur_enable = 1'b1;

	bus_phase_t           bus_phase = BUS_IDLE;
	logic                 word_taken = 1'b0;
	int                   burst_left = 1;
	int                   gap_left = 0;

	int                   words_queued = 0;
	int                   words_taken = 0;
	int                   cycle_count = 0;
	int                   error_count = 0;
	int                   n_stored = 0;
	int                   n_overflows = 0;
	int                   n_clears = 0;
	int                   n_found = 0;
	int                   n_missed = 0;
	int                   n_writes = 0;

	expiring_entry_select_buffer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.now_ticks      (now_ticks),
		.entry_tag      (entry_tag),
		.entry_kind     (entry_kind),
		.entry_priority (entry_priority),
		.entry_lifetime (entry_lifetime),
		.done           (done),
		.accepted       (accepted),
		.overflow       (overflow),
		.found          (found),
		.found_index    (found_index),
		.found_tag      (found_tag),
		.found_kind     (found_kind),
		.found_priority (found_priority)
	);

	always #5 clk = ~clk;

	// live when lifetime is zero or the wrapped age is within it
	function automatic logic is_live(input int pos, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] age;
		age = now - held_entries[pos].push_time;
		return held_entries[pos].lifetime == '0 || age <= held_entries[pos].lifetime;
	endfunction

	function automatic int choose_entry(input logic [TIME_W-1:0] now);
		int               best;
		logic [PRIO_W-1:0] best_prio;
		best = -1;
		best_prio = '0;
		case (cur_policy)
		POL_FIRST_LIVE: begin
			for (int i = 0; i < held_count; i++)
				if (best < 0 && is_live(i, now))
					best = i;
		end
		POL_LAST_LIVE: begin
			for (int i = 0; i < held_count; i++)
				if (is_live(i, now))
					best = i;
		end
		POL_FIRST: begin
			if (held_count > 0)
				best = 0;
		end
		POL_LAST: begin
			if (held_count > 0)
				best = held_count - 1;
		end
		default: begin
			// ties go to the later entry
			for (int i = 0; i < held_count; i++)
				if (is_live(i, now) && held_entries[i].prio >= best_prio) begin
					best_prio = held_entries[i].prio;
					best = i;
				end
		end
		endcase
		return best;
	endfunction

	function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
		input logic [TIME_W-1:0] now, input entry_t fresh);
		outcome_t res;
		int       pick;
		res = '0;
		case (cmd)
		CMD_CLEAR: begin
			held_count = 0;
			res.accepted = 1'b1;
			n_clears++;
		end
		CMD_PUSH: begin
			if (cur_enable) begin
				if (held_count >= DEPTH) begin
					res.overflow = 1'b1;
					n_overflows++;
				end else begin
					held_entries[held_count] = fresh;
					held_count++;
					res.accepted = 1'b1;
					n_stored++;
				end
			end
		end
		CMD_SELECT: begin
			pick = cur_enable ? choose_entry(now) : -1;
			if (pick >= 0) begin
				res.found = 1'b1;
				res.index = pick[OIDX_W-1:0];
				res.tag = held_entries[pick].tag;
				res.kind = held_entries[pick].kind;
				res.prio = held_entries[pick].prio;
				n_found++;
			end else begin
				n_missed++;
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// monitor: checks result words, predicts accepted words, tracks register writes
	always @(posedge clk) begin : watch
		entry_t   fresh;
		outcome_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result word with none expected", $time);
					error_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("overflow", want.overflow, overflow);
					check_field("found", want.found, found);
					check_field("found_index", want.index, found_index);
					check_field("found_tag", want.tag, found_tag);
					check_field("found_kind", want.kind, found_kind);
					check_field("found_priority", want.prio, found_priority);
				end
			end
			if (start && !busy) begin
				fresh.tag = entry_tag;
				fresh.kind = entry_kind;
				fresh.prio = entry_priority;
				fresh.push_time = now_ticks;
				fresh.lifetime = entry_lifetime;
				predicted_results.push_back(apply_command(command, now_ticks, fresh));
				words_taken++;
				word_taken = 1'b1;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[APB_AW-1:2] == REG_POLICY)
					cur_policy = pwdata[POL_W-1:0];
				else if (paddr[APB_AW-1:2] == REG_ENABLE)
					cur_enable = pwdata[0];
				n_writes++;
			end
		end
	end

	// driver: works through pending ops in bursts, with apb writes between phases
	always @(negedge clk) begin : drive
		pending_op_t op;
		logic        nxt_start;
		logic        nxt_psel;
		logic        nxt_penable;
		nxt_start = start;
		nxt_psel = psel;
		nxt_penable = penable;
		if (arst_n) begin
			if (start && word_taken)
				nxt_start = 1'b0;
			if (bus_phase == BUS_SETUP) begin
				nxt_penable = 1'b1;
				bus_phase = BUS_ACCESS;
			end else if (bus_phase == BUS_ACCESS) begin
				nxt_psel = 1'b0;
				nxt_penable = 1'b0;
				pwrite <= 1'b0;
				bus_phase = BUS_IDLE;
			end else if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					op = pending_ops[0];
					case (op.action)
					OP_WORD: begin
						pending_ops.delete(0);
						command <= op.cmd;
						now_ticks <= op.now;
						entry_tag <= op.tag;
						entry_kind <= op.kind_code;
						entry_priority <= op.prio;
						entry_lifetime <= op.lifetime;
						nxt_start = 1'b1;
						burst_left--;
						if (burst_left <= 0) begin
							burst_left = $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
						end
					end
					OP_WRITE: begin
						pending_ops.delete(0);
						nxt_psel = 1'b1;
						nxt_penable = 1'b0;
						pwrite <= 1'b1;
						paddr <= {op.reg_idx, 2'b00};
						pwdata <= op.reg_val;
						bus_phase = BUS_SETUP;
					end
					default: begin
						if (predicted_results.size() == 0)
							pending_ops.delete(0);
					end
					endcase
				end
			end
		end
		word_taken = 1'b0;
		start <= nxt_start;
		psel <= nxt_psel;
		penable <= nxt_penable;
	end

	task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
		input logic [TAG_W-1:0] tag, input logic [KIND_W-1:0] kind_code,
		input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] lifetime);
		pending_op_t op;
		op.action = OP_WORD;
		op.cmd = cmd;
		op.now = now;
		op.tag = tag;
		op.kind_code = kind_code;
		op.prio = prio;
		op.lifetime = lifetime;
		op.reg_idx = '0;
		op.reg_val = '0;
		pending_ops.push_back(op);
		words_queued++;
	endtask

	task automatic queue_drain();
		pending_op_t op;
		op.action = OP_DRAIN;
		pending_ops.push_back(op);
	endtask

	task automatic queue_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
		pending_op_t op;
		queue_drain();
		op.action = OP_WRITE;
		op.reg_idx = idx;
		op.reg_val = val;
		pending_ops.push_back(op);
	endtask

	initial begin : stimulus
		logic [POL_W-1:0]  pol;
		logic [TIME_W-1:0] tick;
		logic [TIME_W-1:0] life;
		int                phase;
		int                len;
		int                r;
		int                random_words;
		logic [POL_W-1:0]  pol_list[6];

		burst_left = $urandom_range(1, 24);

		// empty select, extreme fields, wrapped ages, fill to full, overflow
		queue_word(CMD_SELECT, '0, '0, '0, '0, '0);
		queue_word(CMD_PUSH, 32'hFFFF_FFF0, 8'hFF, 3'd7, 8'h00, '0);
		queue_word(CMD_PUSH, 32'hFFFF_FFF0, 8'h00, 3'd0, 8'hFF, 32'h20);
		queue_word(CMD_PUSH, 32'h0000_0000, 8'h5A, 3'd2, 8'hFF, 32'hFFFF_FFFF);
		queue_word(CMD_PUSH, 32'h0000_0005, 8'hA5, 3'd5, 8'hFF, 32'h1);
		queue_word(CMD_SELECT, 32'h0000_0010, '0, '0, '0, '0);
		queue_word(CMD_SELECT, 32'h0000_0011, '1, '1, '1, '1);
		queue_word(CMD_UNUSED, '1, '1, '1, '1, '1);
		for (int i = 4; i < DEPTH; i++)
			queue_word(CMD_PUSH, 32'd100 + i, TAG_W'(i * 17), KIND_W'(i), PRIO_W'(i * 16),
				TIME_W'(i * 8));
		queue_word(CMD_PUSH, 32'd200, 8'h33, 3'd3, 8'hFF, '0);

		// every policy over the full buffer, unused code included
		pol_list = '{POL_FIRST_LIVE, POL_LAST_LIVE, POL_FIRST, POL_LAST, POL_HIGH_PRIO,
			POL_SPARE};
		foreach (pol_list[k]) begin
			queue_write(REG_POLICY, APB_DW'(pol_list[k]));
			queue_word(CMD_SELECT, 32'd200, '0, '0, '0, '0);
		end

		// disabled: push and select refused, clear still acts
		queue_write(REG_ENABLE, '0);
		queue_word(CMD_PUSH, 32'd210, 8'h11, 3'd1, 8'h11, 32'd5);
		queue_word(CMD_SELECT, 32'd210, '0, '0, '0, '0);
		queue_word(CMD_CLEAR, 32'd210, '0, '0, '0, '0);
		queue_write(REG_ENABLE, APB_DW'(1));
		queue_word(CMD_SELECT, 32'd211, '0, '0, '0, '0);

		// random phases: each starts with a clear, then pushes and selects on a
		// moving clock so that entries age out, with some noise mixed in
		random_words = 0;
		phase = 0;
		while (random_words < 600) begin
			if (phase < 8)
				pol = POL_W'(phase);
			else if ($urandom_range(0, 9) < 8)
				pol = POL_W'($urandom_range(0, 4));
			else
				pol = POL_W'($urandom_range(5, 7));
			queue_write(REG_POLICY, APB_DW'(pol));
			queue_write(REG_ENABLE, APB_DW'(phase % 6 != 5));
			len = (phase % 6 == 5) ? $urandom_range(8, 16) : $urandom_range(25, 60);
			tick = (phase % 4 == 3) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
			queue_word(CMD_CLEAR, tick, $urandom, $urandom, $urandom, $urandom);
			repeat (len) begin
				tick += $urandom_range(0, 12);
				if ($urandom_range(0, 39) == 0)
					tick += $urandom;
				case ($urandom_range(0, 9))
				0, 1: life = '0;
				2: life = $urandom;
				3: life = '1;
				default: life = $urandom_range(1, 80);
				endcase
				r = $urandom_range(0, 99);
				if (r < 45)
					queue_word(CMD_PUSH, tick, $urandom, $urandom, $urandom, life);
				else if (r < 85)
					queue_word(CMD_SELECT, tick, $urandom, $urandom, $urandom, life);
				else if (r < 91)
					queue_word(CMD_CLEAR, tick, $urandom, $urandom, $urandom, life);
				else if (r < 95)
					queue_word(CMD_UNUSED, tick, $urandom, $urandom, $urandom, life);
				else
					queue_word(CMD_W'($urandom), $urandom, $urandom, $urandom, $urandom,
						$urandom);
				if ($urandom_range(0, 59) == 0)
					queue_drain();
			end
			if (phase % 6 != 5)
				random_words += len + 1;
			phase++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_taken != words_queued || predicted_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d words over %0d phases: %0d stored, %0d overflows, %0d clears",
			words_taken, phase, n_stored, n_overflows, n_clears);
		$display("selects with an entry %0d, without %0d; register writes %0d",
			n_found, n_missed, n_writes);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
